[hdl/psd_pkg.sv]
// types, widths and iteration steps shared by the point-to-segment distance pipeline
package psd_pkg;

  localparam int CW  = 24;          // coordinate width
  localparam int DW  = CW + 1;      // coordinate difference width
  localparam int SSW = 2 * DW;      // sum-of-squares width
  localparam int RTW = DW;          // square root width
  localparam int LW  = RTW;         // segment length width
  localparam int QW  = DW + 1;      // quotient magnitude width
  localparam int NW  = DW + QW;     // dividend width
  localparam int OW  = CW + 2;      // wide result width
  localparam int SQN = RTW;         // square root steps
  localparam int DVN = QW;          // divider steps

  typedef logic signed [CW-1:0]  coord_t;
  typedef logic signed [DW-1:0]  diff_t;
  typedef logic signed [SSW-1:0] prod_t;

  typedef enum logic [1:0] {
    REG_WITHIN = 2'd0,
    REG_BEFORE = 2'd1,
    REG_PAST   = 2'd2
  } region_t;

  typedef struct packed {
    coord_t [2:0]          p;
    coord_t [2:0]          s;
    coord_t [2:0]          e;
    diff_t  [2:0]          d;
    logic                  dot_neg;
    logic [NW-1:0]         dmag;
    region_t               region;
    logic                  zero;
    logic [SSW-1:0]        orad;
    logic [LW-1:0]         len;
    logic signed [QW:0]    along;
    logic [2:0]            off_neg;
    coord_t [2:0]          c;
  } pl_t;

  typedef struct packed {
    logic [RTW+1:0] rem;
    logic [RTW-1:0] root;
    logic [SSW-1:0] rad;
  } sq_st_t;

  typedef struct packed {
    logic [LW-1:0] rem;
    logic [QW-1:0] nq;
  } dv_st_t;

  function automatic sq_st_t sq_init(input logic [SSW-1:0] n);
    sq_st_t st;
    st.rem  = '0;
    st.root = '0;
    st.rad  = n;
    return st;
  endfunction

  // one root bit of the restoring square root, from the next radicand bit pair
  function automatic sq_st_t sq_step(input sq_st_t st);
    logic [RTW+3:0] t;
    logic [RTW+3:0] trial;
    sq_st_t nx;
    t      = {st.rem, st.rad[SSW-1 -: 2]};
    trial  = {2'b00, st.root, 2'b01};
    nx.rad = {st.rad[SSW-3:0], 2'b00};
    if (t >= trial) begin
      nx.rem  = (RTW+2)'(t - trial);
      nx.root = {st.root[RTW-2:0], 1'b1};
    end else begin
      nx.rem  = (RTW+2)'(t);
      nx.root = {st.root[RTW-2:0], 1'b0};
    end
    return nx;
  endfunction

  // quotient is known to fit in QW bits, so the upper dividend bits preload the remainder
  function automatic dv_st_t dv_init(input logic [NW-1:0] n);
    dv_st_t st;
    st.rem = n[NW-1:QW];
    st.nq  = n[QW-1:0];
    return st;
  endfunction

  // one restoring division bit
  function automatic dv_st_t dv_step(input dv_st_t st, input logic [LW-1:0] den);
    logic [LW:0] t;
    logic [LW:0] dn;
    dv_st_t nx;
    t  = {st.rem, st.nq[QW-1]};
    dn = {1'b0, den};
    if (t >= dn) begin
      nx.rem = LW'(t - dn);
      nx.nq  = {st.nq[QW-2:0], 1'b1};
    end else begin
      nx.rem = LW'(t);
      nx.nq  = {st.nq[QW-2:0], 1'b0};
    end
    return nx;
  endfunction

  function automatic logic is_inner(input pl_t pl);
    return (pl.region == REG_WITHIN) && !pl.zero;
  endfunction

endpackage

[hdl/point_segment_distance_3d.sv]
// point to 3d segment distance: fully pipelined, one transaction per cycle while the output is not stalled
// throughput: one transaction per cycle; the whole pipeline holds while a result is stalled
// the latency is set by two 25-step square roots and two 26-step dividers in series
// reset: synchronous, active low, clears every valid bit; datapath registers are not reset
module point_segment_distance_3d (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  psd_pkg::coord_t            in_point_x,
  input  psd_pkg::coord_t            in_point_y,
  input  psd_pkg::coord_t            in_point_z,
  input  psd_pkg::coord_t            in_seg_start_x,
  input  psd_pkg::coord_t            in_seg_start_y,
  input  psd_pkg::coord_t            in_seg_start_z,
  input  psd_pkg::coord_t            in_seg_end_x,
  input  psd_pkg::coord_t            in_seg_end_y,
  input  psd_pkg::coord_t            in_seg_end_z,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [psd_pkg::OW-1:0] out_signed_distance,
  output logic signed [psd_pkg::OW-1:0] out_along_ray,
  output psd_pkg::coord_t            out_closest_x,
  output psd_pkg::coord_t            out_closest_y,
  output psd_pkg::coord_t            out_closest_z,
  output logic [1:0]                 out_region
);
  import psd_pkg::*;

  // global advance: every stage moves when the output register is free or being taken
  logic en;

  // stage 1: differences d = e - s, t = p - s, u = p - e
  coord_t [2:0] in_p, in_s, in_e;
  pl_t          s1_pl_nxt, s1_pl_r;
  diff_t [2:0]  s1_t_nxt, s1_u_nxt, s1_t_r, s1_u_r;
  logic         s1_v_r;

  // stage 2: products
  prod_t [2:0]  s2_dt_r, s2_dd_r, s2_tt_r, s2_uu_r;
  pl_t          s2_pl_r;
  logic         s2_v_r;

  // stage 3: dot product, squared lengths, region decision
  logic signed [NW-1:0] dot3;
  logic [SSW-1:0]       l2_3, tt3, uu3;
  pl_t                  s3_pl_nxt, s3_pl_r;
  logic [SSW-1:0]       s3_l2_r;
  logic                 s3_v_r;

  // square root of |d|^2 gives the segment length
  logic [SQN:1] sqa_v_r;
  pl_t          sqa_pl_r [1:SQN];
  sq_st_t       sqa_st_r [1:SQN];

  // projection: |dot| / len
  pl_t          dvb_src;
  logic [DVN:1] dvb_v_r;
  pl_t          dvb_pl_r [1:DVN];
  dv_st_t       dvb_st_r [1:DVN];

  // signed projection and the offset products |d_i| * along
  pl_t             mm_pl_nxt, mm_pl_r;
  logic [NW-1:0]   mm_pd_nxt [3];
  logic [NW-1:0]   mm_pd_r   [3];
  logic            mm_v_r;

  // offsets along the segment: |d_i| * along / len
  logic [DVN:1] dvc_v_r;
  pl_t          dvc_pl_r [1:DVN];
  dv_st_t       dvc_st_r [1:DVN][3];

  // nearest point; the unwrapped copy keeps the residual exact when
  // truncation steps just past an endpoint at the edge of the range
  pl_t                     cc_pl_nxt, cc_pl_r;
  logic signed [2:0][QW:0] cc_f_nxt, cc_f_r;
  logic                    cc_v_r;

  // residual, squares, radicand pick
  logic [2:0][DW:0] ww_r;
  pl_t            ww_pl_r;
  logic           ww_v_r;
  prod_t [2:0]    qq_r;
  pl_t            qq_pl_r;
  logic           qq_v_r;
  logic [SSW-1:0] rr_rad_nxt, rr_rad_r;
  pl_t            rr_pl_r;
  logic           rr_v_r;

  // square root of the chosen radicand gives the distance
  logic [SQN:1] sqd_v_r;
  pl_t          sqd_pl_r [1:SQN];
  sq_st_t       sqd_st_r [1:SQN];

  // output register
  logic                 out_valid_r;
  logic signed [OW-1:0] out_dist_r, out_along_r;
  coord_t [2:0]         out_c_r;
  region_t              out_region_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  assign in_p = {in_point_z, in_point_y, in_point_x};
  assign in_s = {in_seg_start_z, in_seg_start_y, in_seg_start_x};
  assign in_e = {in_seg_end_z, in_seg_end_y, in_seg_end_x};

  // ---------------- stage 1 ----------------
  always_comb begin
    s1_pl_nxt   = '0;
    s1_pl_nxt.p = in_p;
    s1_pl_nxt.s = in_s;
    s1_pl_nxt.e = in_e;
    for (int i = 0; i < 3; i++) begin
      s1_pl_nxt.d[i] = DW'($signed(in_e[i])) - DW'($signed(in_s[i]));
      s1_t_nxt[i]    = DW'($signed(in_p[i])) - DW'($signed(in_s[i]));
      s1_u_nxt[i]    = DW'($signed(in_p[i])) - DW'($signed(in_e[i]));
    end
  end

  // ---------------- valid chain ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      sqa_v_r     <= '0;
      dvb_v_r     <= '0;
      mm_v_r      <= 1'b0;
      dvc_v_r     <= '0;
      cc_v_r      <= 1'b0;
      ww_v_r      <= 1'b0;
      qq_v_r      <= 1'b0;
      rr_v_r      <= 1'b0;
      sqd_v_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_v_r      <= in_valid;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      sqa_v_r     <= {sqa_v_r[SQN-1:1], s3_v_r};
      dvb_v_r     <= {dvb_v_r[DVN-1:1], sqa_v_r[SQN]};
      mm_v_r      <= dvb_v_r[DVN];
      dvc_v_r     <= {dvc_v_r[DVN-1:1], mm_v_r};
      cc_v_r      <= dvc_v_r[DVN];
      ww_v_r      <= cc_v_r;
      qq_v_r      <= ww_v_r;
      rr_v_r      <= qq_v_r;
      sqd_v_r     <= {sqd_v_r[SQN-1:1], rr_v_r};
      out_valid_r <= sqd_v_r[SQN];
    end
  end

  // ---------------- stages 1 and 2 data ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      s1_pl_r <= s1_pl_nxt;
      s1_t_r  <= s1_t_nxt;
      s1_u_r  <= s1_u_nxt;
      s2_pl_r <= s1_pl_r;
      for (int i = 0; i < 3; i++) begin
        s2_dt_r[i] <= prod_t'($signed(s1_pl_r.d[i])) * prod_t'($signed(s1_t_r[i]));
        s2_dd_r[i] <= prod_t'($signed(s1_pl_r.d[i])) * prod_t'($signed(s1_pl_r.d[i]));
        s2_tt_r[i] <= prod_t'($signed(s1_t_r[i])) * prod_t'($signed(s1_t_r[i]));
        s2_uu_r[i] <= prod_t'($signed(s1_u_r[i])) * prod_t'($signed(s1_u_r[i]));
      end
    end
  end

  // ---------------- stage 3: region ----------------
  always_comb begin
    dot3 = NW'($signed(s2_dt_r[0])) + NW'($signed(s2_dt_r[1])) + NW'($signed(s2_dt_r[2]));
    l2_3 = $unsigned(s2_dd_r[0]) + $unsigned(s2_dd_r[1]) + $unsigned(s2_dd_r[2]);
    tt3  = $unsigned(s2_tt_r[0]) + $unsigned(s2_tt_r[1]) + $unsigned(s2_tt_r[2]);
    uu3  = $unsigned(s2_uu_r[0]) + $unsigned(s2_uu_r[1]) + $unsigned(s2_uu_r[2]);

    s3_pl_nxt         = s2_pl_r;
    s3_pl_nxt.zero    = (l2_3 == '0);
    s3_pl_nxt.dot_neg = dot3[NW-1];
    s3_pl_nxt.dmag    = dot3[NW-1] ? $unsigned(-dot3) : $unsigned(dot3);
    // a zero-length segment counts as within, nearest point the start
    if (l2_3 == '0) begin
      s3_pl_nxt.region = REG_WITHIN;
    end else if (dot3[NW-1]) begin
      s3_pl_nxt.region = REG_BEFORE;
    end else if (dot3[NW-2:0] > l2_3) begin
      s3_pl_nxt.region = REG_PAST;
    end else begin
      s3_pl_nxt.region = REG_WITHIN;
    end
    // outside cases measure to the endpoint; within uses the nearest point later
    s3_pl_nxt.orad = (s3_pl_nxt.region == REG_PAST) ? uu3 : tt3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_pl_r <= s3_pl_nxt;
      s3_l2_r <= l2_3;
    end
  end

  // ---------------- length square root ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      sqa_pl_r[1] <= s3_pl_r;
      sqa_st_r[1] <= sq_step(sq_init(s3_l2_r));
      for (int k = 2; k <= SQN; k++) begin
        sqa_pl_r[k] <= sqa_pl_r[k-1];
        sqa_st_r[k] <= sq_step(sqa_st_r[k-1]);
      end
    end
  end

  // ---------------- projection divider ----------------
  always_comb begin
    dvb_src     = sqa_pl_r[SQN];
    dvb_src.len = sqa_st_r[SQN].root;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvb_pl_r[1] <= dvb_src;
      dvb_st_r[1] <= dv_step(dv_init(dvb_src.dmag), dvb_src.len);
      for (int k = 2; k <= DVN; k++) begin
        dvb_pl_r[k] <= dvb_pl_r[k-1];
        dvb_st_r[k] <= dv_step(dvb_st_r[k-1], dvb_pl_r[k-1].len);
      end
    end
  end

  // ---------------- signed projection, offset products ----------------
  always_comb begin
    logic [DW-1:0] magd;
    logic [QW-1:0] q;
    q         = dvb_st_r[DVN].nq;
    mm_pl_nxt = dvb_pl_r[DVN];
    // zero length has no projection
    if (mm_pl_nxt.zero) begin
      mm_pl_nxt.along = '0;
    end else if (mm_pl_nxt.dot_neg) begin
      mm_pl_nxt.along = -$signed({1'b0, q});
    end else begin
      mm_pl_nxt.along = $signed({1'b0, q});
    end
    for (int i = 0; i < 3; i++) begin
      magd = mm_pl_nxt.d[i][DW-1] ? $unsigned(-$signed(mm_pl_nxt.d[i]))
                                  : $unsigned(mm_pl_nxt.d[i]);
      mm_pl_nxt.off_neg[i] = mm_pl_nxt.d[i][DW-1] ^ mm_pl_nxt.dot_neg;
      mm_pd_nxt[i] = NW'(magd) * NW'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mm_pl_r <= mm_pl_nxt;
      for (int i = 0; i < 3; i++) begin
        mm_pd_r[i] <= mm_pd_nxt[i];
      end
    end
  end

  // ---------------- offset dividers, one lane per axis ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      dvc_pl_r[1] <= mm_pl_r;
      for (int i = 0; i < 3; i++) begin
        dvc_st_r[1][i] <= dv_step(dv_init(mm_pd_r[i]), mm_pl_r.len);
      end
      for (int k = 2; k <= DVN; k++) begin
        dvc_pl_r[k] <= dvc_pl_r[k-1];
        for (int i = 0; i < 3; i++) begin
          dvc_st_r[k][i] <= dv_step(dvc_st_r[k-1][i], dvc_pl_r[k-1].len);
        end
      end
    end
  end

  // ---------------- nearest point ----------------
  always_comb begin
    logic signed [QW:0] off;
    logic signed [QW:0] full;
    cc_pl_nxt = dvc_pl_r[DVN];
    for (int i = 0; i < 3; i++) begin
      off  = cc_pl_nxt.off_neg[i] ? -$signed({1'b0, dvc_st_r[DVN][i].nq})
                                  :  $signed({1'b0, dvc_st_r[DVN][i].nq});
      full = (QW+1)'($signed(cc_pl_nxt.s[i])) + off;
      cc_f_nxt[i] = full;
      if (is_inner(cc_pl_nxt)) begin
        cc_pl_nxt.c[i] = CW'(full);
      end else if (cc_pl_nxt.region == REG_PAST) begin
        cc_pl_nxt.c[i] = cc_pl_nxt.e[i];
      end else begin
        cc_pl_nxt.c[i] = cc_pl_nxt.s[i];
      end
    end
  end

  // ---------------- residual, squares, radicand ----------------
  always_comb begin
    rr_rad_nxt = $unsigned(qq_r[0]) + $unsigned(qq_r[1]) + $unsigned(qq_r[2]);
    if (!is_inner(qq_pl_r)) begin
      rr_rad_nxt = qq_pl_r.orad;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cc_pl_r <= cc_pl_nxt;
      cc_f_r  <= cc_f_nxt;
      ww_pl_r <= cc_pl_r;
      qq_pl_r <= ww_pl_r;
      rr_pl_r <= qq_pl_r;
      rr_rad_r <= rr_rad_nxt;
      for (int i = 0; i < 3; i++) begin
        ww_r[i] <= (DW+1)'($signed(cc_pl_r.p[i])) - (DW+1)'($signed(cc_f_r[i]));
        qq_r[i] <= prod_t'($signed(ww_r[i])) * prod_t'($signed(ww_r[i]));
      end
    end
  end

  // ---------------- distance square root ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      sqd_pl_r[1] <= rr_pl_r;
      sqd_st_r[1] <= sq_step(sq_init(rr_rad_r));
      for (int k = 2; k <= SQN; k++) begin
        sqd_pl_r[k] <= sqd_pl_r[k-1];
        sqd_st_r[k] <= sq_step(sqd_st_r[k-1]);
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      // endpoint distances come out negated
      if (sqd_pl_r[SQN].region != REG_WITHIN) begin
        out_dist_r <= -$signed(OW'(sqd_st_r[SQN].root));
      end else begin
        out_dist_r <= $signed(OW'(sqd_st_r[SQN].root));
      end
      out_along_r  <= OW'(sqd_pl_r[SQN].along);
      out_c_r      <= sqd_pl_r[SQN].c;
      out_region_r <= sqd_pl_r[SQN].region;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_signed_distance = out_dist_r;
  assign out_along_ray       = out_along_r;
  assign out_closest_x       = out_c_r[0];
  assign out_closest_y       = out_c_r[1];
  assign out_closest_z       = out_c_r[2];
  assign out_region          = out_region_r;

`ifndef ASSERT_OFF
  a_outside_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_region_r != REG_WITHIN) |-> out_dist_r[OW-1] || (out_dist_r == '0))
    else $error("endpoint distance must not be positive");

  a_within_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_region_r == REG_WITHIN) |-> !out_dist_r[OW-1])
    else $error("within-segment distance must not be negative");

  a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(sqd_v_r) && $stable(dvb_v_r) && $stable(dvc_v_r))
    else $error("pipeline moved while output stalled");

  a_zero_within: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && s3_pl_r.zero |-> s3_pl_r.region == REG_WITHIN)
    else $error("zero-length segment must be within");
`endif

endmodule

[tb/sv/tb_point_segment_distance_3d.sv]
// testbench for the 3d point-to-segment distance pipeline
module tb_point_segment_distance_3d;
  timeunit 1ns;
  timeprecision 1ps;
  import psd_pkg::*;

  localparam int LATENCY = 4 * (CW + 1) + 11;

  // one query and its expected answer
  typedef struct {
    logic signed [CW-1:0] p [3];
    logic signed [CW-1:0] s [3];
    logic signed [CW-1:0] e [3];
  } query_t;

  typedef struct {
    logic [OW-1:0] sdist;
    logic [OW-1:0] along;
    logic [CW-1:0] c [3];
    region_t       region;
  } answer_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  coord_t in_point_x, in_point_y, in_point_z;
  coord_t in_seg_start_x, in_seg_start_y, in_seg_start_z;
  coord_t in_seg_end_x, in_seg_end_y, in_seg_end_z;
  logic out_valid;
  logic out_stall;
  logic signed [OW-1:0] out_signed_distance;
  logic signed [OW-1:0] out_along_ray;
  coord_t out_closest_x, out_closest_y, out_closest_z;
  logic [1:0] out_region;

  answer_t pending_answers [$];
  int      mismatches;
  bit      idle_enable;

  point_segment_distance_3d u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_point_x          (in_point_x),
    .in_point_y          (in_point_y),
    .in_point_z          (in_point_z),
    .in_seg_start_x      (in_seg_start_x),
    .in_seg_start_y      (in_seg_start_y),
    .in_seg_start_z      (in_seg_start_z),
    .in_seg_end_x        (in_seg_end_x),
    .in_seg_end_y        (in_seg_end_y),
    .in_seg_end_z        (in_seg_end_z),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_signed_distance (out_signed_distance),
    .out_along_ray       (out_along_ray),
    .out_closest_x       (out_closest_x),
    .out_closest_y       (out_closest_y),
    .out_closest_z       (out_closest_z),
    .out_region          (out_region)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // integer square root, floor, by bit-pair restoring method
  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // quotient truncated toward zero, divisor positive
  function automatic longint div_toward_zero(input longint a, input longint b);
    longint unsigned q;
    q = (a < 0 ? -a : a) / b;
    return a < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned norm_sq(input longint v [3]);
    return v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
  endfunction

  // nearest point on the segment, projection and signed distance
  function automatic answer_t nearest_on_segment(input query_t q);
    answer_t a;
    longint p [3], s [3], e [3], t [3], d [3], w [3], c [3];
    longint dot, along, sd;
    longint unsigned l2, len;
    dot = 0;
    along = 0;
    for (int i = 0; i < 3; i++) begin
      p[i] = q.p[i];
      s[i] = q.s[i];
      e[i] = q.e[i];
      t[i] = p[i] - s[i];
      d[i] = e[i] - s[i];
      dot += d[i] * t[i];
    end
    l2 = norm_sq(d);
    len = floor_sqrt(l2);
    a.region = REG_WITHIN;
    if (len == 0) begin
      c = s;
      sd = floor_sqrt(norm_sq(t));
    end else begin
      along = div_toward_zero(dot, len);
      if (dot < 0) begin
        a.region = REG_BEFORE;
        c = s;
        sd = -longint'(floor_sqrt(norm_sq(t)));
      end else if (dot > longint'(l2)) begin
        a.region = REG_PAST;
        c = e;
        for (int i = 0; i < 3; i++) w[i] = p[i] - e[i];
        sd = -longint'(floor_sqrt(norm_sq(w)));
      end else begin
        for (int i = 0; i < 3; i++) begin
          c[i] = s[i] + div_toward_zero(d[i] * along, len);
          w[i] = p[i] - c[i];
        end
        sd = floor_sqrt(norm_sq(w));
      end
    end
    a.sdist = OW'(sd);
    a.along = OW'(along);
    for (int i = 0; i < 3; i++) a.c[i] = CW'(c[i]);
    return a;
  endfunction

  function automatic bit idle_now();
    return idle_enable && ($urandom_range(99) < 33);
  endfunction

  // drive one query, hold it until accepted, record its answer
  task automatic send_query(input query_t q);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_point_x     <= q.p[0];
    in_point_y     <= q.p[1];
    in_point_z     <= q.p[2];
    in_seg_start_x <= q.s[0];
    in_seg_start_y <= q.s[1];
    in_seg_start_z <= q.s[2];
    in_seg_end_x   <= q.e[0];
    in_seg_end_y   <= q.e[1];
    in_seg_end_z   <= q.e[2];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_answers.push_back(nearest_on_segment(q));
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
  endtask

  // result side: random stall, compare every accepted transaction
  always @(posedge clk) begin
    answer_t x;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_answers.size() == 0) begin
          $error("result with no query waiting");
          mismatches++;
        end else begin
          x = pending_answers.pop_front();
          if (out_signed_distance !== x.sdist) begin
            $error("signed_distance exp %0d got %0d", $signed(x.sdist), out_signed_distance);
            mismatches++;
          end
          if (out_along_ray !== x.along) begin
            $error("along_ray exp %0d got %0d", $signed(x.along), out_along_ray);
            mismatches++;
          end
          if (out_closest_x !== x.c[0]) begin
            $error("closest_x exp %0d got %0d", $signed(x.c[0]), out_closest_x);
            mismatches++;
          end
          if (out_closest_y !== x.c[1]) begin
            $error("closest_y exp %0d got %0d", $signed(x.c[1]), out_closest_y);
            mismatches++;
          end
          if (out_closest_z !== x.c[2]) begin
            $error("closest_z exp %0d got %0d", $signed(x.c[2]), out_closest_z);
            mismatches++;
          end
          if (out_region !== x.region) begin
            $error("region exp %0d got %0d", x.region, out_region);
            mismatches++;
          end
        end
      end
    end
    out_stall <= idle_now();
  end

  function automatic coord_t rand_coord(input int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(511)) - 256);
      default: return coord_t'($signed($urandom_range(131071)) - 65536);
    endcase
  endfunction

  function automatic query_t make_query(input coord_t px, py, pz, sx, sy, sz,
                                        ex, ey, ez);
    query_t q;
    q.p[0] = px; q.p[1] = py; q.p[2] = pz;
    q.s[0] = sx; q.s[1] = sy; q.s[2] = sz;
    q.e[0] = ex; q.e[1] = ey; q.e[2] = ez;
    return q;
  endfunction

  // endpoints, zero-length segments and all three regions
  task automatic test_directed();
    coord_t mx, mn;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    // zero-length segment
    send_query(make_query(256, 512, -768, 0, 0, 0, 0, 0, 0));
    send_query(make_query(mx, mx, mx, mn, mn, mn, mn, mn, mn));
    // inside, before start, past end
    send_query(make_query(512, 256, 0, 0, 0, 0, 1024, 0, 0));
    send_query(make_query(-512, 256, 0, 0, 0, 0, 1024, 0, 0));
    send_query(make_query(2048, 256, 77, 0, 0, 0, 1024, 0, 0));
    // projection exactly at each endpoint
    send_query(make_query(0, 300, 0, 0, 0, 0, 1024, 0, 0));
    send_query(make_query(1024, 300, 0, 0, 0, 0, 1024, 0, 0));
    // extreme coordinates
    send_query(make_query(mx, mx, mx, mn, mn, mn, mx, mx, mx));
    send_query(make_query(mn, mn, mn, mn, mn, mn, mx, mx, mx));
    send_query(make_query(mx, mn, mx, mx, mn, mn, mn, mx, mx));
    send_query(make_query(mn, mx, mn, mx, mx, mx, mn, mn, mn));
    send_query(make_query(0, 0, 0, mx, 0, 0, mn, 0, 0));
    send_query(make_query(-1, -1, -1, 1, 1, 1, 3, -5, 7));
    send_query(make_query(mx, 0, mn, 0, mx, 0, 0, mn, 0));
    // truncation steps the nearest point just past an end at the top of the range
    send_query(make_query(mx, mx, 0, mx - 1, mx - 1, 0, mx, mx, 0));
    go_idle();
  endtask

  task automatic test_random(input int count);
    query_t q;
    int mode;
    for (int n = 0; n < count; n++) begin
      idle_enable = !(n >= count / 3 && n < count / 3 + 200);
      mode = $urandom_range(2);
      for (int i = 0; i < 3; i++) begin
        q.p[i] = rand_coord(mode);
        q.s[i] = rand_coord(mode);
        q.e[i] = rand_coord(mode);
      end
      // now and then a degenerate or axis-aligned segment
      if ($urandom_range(19) == 0) q.e = q.s;
      else if ($urandom_range(19) == 0) begin
        q.e[1] = q.s[1];
        q.e[2] = q.s[2];
      end
      send_query(q);
    end
    go_idle();
    idle_enable = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    in_point_x = '0; in_point_y = '0; in_point_z = '0;
    in_seg_start_x = '0; in_seg_start_y = '0; in_seg_start_z = '0;
    in_seg_end_x = '0; in_seg_end_y = '0; in_seg_end_z = '0;
    mismatches = 0;
    idle_enable = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1950);
    // drain, then let the pipeline settle
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0 && pending_answers.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
